// ===== src/step_pulse_train_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer assertion macros
// Shared checking macros for the sequencer modules; they vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef STEP_PULSE_TRAIN_SEQUENCER_TOP_ASSERT_SVH
`define STEP_PULSE_TRAIN_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sptseq check failed");
`define SPTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sptseq check failed");
`define SPTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sptseq check failed");
`else
`define SPTS_ASSERT(lbl, prop)
`define SPTS_ASSERT_SAME(lbl, ante, cons)
`define SPTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/sptseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer package
// Sizes, beat types, command codes and the element address helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sptseq_pkg;

  localparam int ELEMS_PER_BUFFER = 16;
  localparam int NUM_BUFFERS      = 4;
  localparam int PERIOD_BITS      = 24;
  localparam int QUEUE_DEPTH      = 4;

  localparam int ELEM_W  = $clog2(ELEMS_PER_BUFFER);
  localparam int BUF_W   = $clog2(NUM_BUFFERS);
  localparam int ADDR_W  = BUF_W + ELEM_W;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_MARK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_MARK,
    OP_START,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  buf_sel;
    logic [3:0]  elem_index;
    logic [15:0] step_count;
    logic [23:0] period_ticks;
    logic        rot_flag;
    logic        laser_flag;
    logic        stop_flag;
  } item_t;

  typedef struct packed {
    logic       pulse_level;
    logic       rot_pin;
    logic       laser_pin;
    logic       running;
    logic [3:0] valid_mask;
    logic       underrun;
    logic       job_done;
  } result_t;

  typedef struct packed {
    logic [15:0]            steps;
    logic [PERIOD_BITS-1:0] period;
    logic                   rot;
    logic                   laser;
    logic                   stop;
  } elem_t;

  typedef struct packed {
    op_t               op;
    logic [BUF_W-1:0]  buf_idx;
    logic [ADDR_W-1:0] addr;
    elem_t             elem;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [BUF_W-1:0] b,
                                                  input logic [ELEM_W-1:0] e);
    elem_addr = {b, e};
  endfunction

endpackage

`default_nettype wire

// ===== src/step_pulse_train_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer
// Four buffers of line elements played out as step pulse trains, one clock
// tick per tick beat, with buffer chaining, stop and underrun handling.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   item_t
//   result   out        result_valid / result_stall  result_t
//
// Every item beat gives exactly one result beat. A write, a mark, an ignored
// start or a plain tick is finished in S_IDLE; a start reads the element store
// and goes on to S_LOAD; a tick that ends a line goes to S_CHECK, then to S_LOAD
// if it loads the next element. The store's read port and the front are registered.
// Reset is synchronous; the element store is not cleared.
// A stalled result holds the back end; the queue keeps accepting until full.
`default_nettype none

module step_pulse_train_sequencer_top
  import sptseq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic q_valid;
  logic q_stall;
  cmd_t q_cmd;

  sptseq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd)
  );

  sptseq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_stall (cmd_stall),
    .push_data  (cmd),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_data   (q_cmd)
  );

  sptseq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_stall      (q_stall),
    .q_cmd        (q_cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== src/sptseq_front.sv =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer front end
// Accepts input beats, decodes and range-checks them into registered commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sptseq_front
  import sptseq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       cmd_valid,
  input  wire logic  cmd_stall,
  output cmd_t       cmd
);

  cmd_t cmd_dec;

  always_comb begin
    cmd_dec.buf_idx     = BUF_W'(item.buf_sel);
    cmd_dec.addr        = elem_addr(BUF_W'(item.buf_sel), ELEM_W'(item.elem_index));
    cmd_dec.elem.steps  = item.step_count;
    cmd_dec.elem.period = PERIOD_BITS'(item.period_ticks);
    cmd_dec.elem.rot    = item.rot_flag;
    cmd_dec.elem.laser  = item.laser_flag;
    cmd_dec.elem.stop   = item.stop_flag;
    case (item.func)
      FUNC_WRITE: begin
        if (int'(item.buf_sel) < NUM_BUFFERS && int'(item.elem_index) < ELEMS_PER_BUFFER) begin
          cmd_dec.op = OP_WRITE;
        end else begin
          cmd_dec.op = OP_NOP;
        end
      end
      FUNC_MARK: begin
        if (int'(item.buf_sel) < NUM_BUFFERS) begin
          cmd_dec.op = OP_MARK;
        end else begin
          cmd_dec.op = OP_NOP;
        end
      end
      FUNC_START: cmd_dec.op = OP_START;
      default:    cmd_dec.op = OP_TICK;
    endcase
  end

  assign item_stall = cmd_valid && cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!item_stall) begin
      cmd_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      cmd <= cmd_dec;
    end
  end

endmodule

`default_nettype wire

// ===== src/sptseq_queue.sv =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer command queue
// Small first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_pulse_train_sequencer_top_assert.svh"

module sptseq_queue
  import sptseq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_stall,
  input  wire cmd_t push_data,
  output logic      pop_valid,
  input  wire logic pop_stall,
  output cmd_t      pop_data
);

  cmd_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  logic               pop;

  assign push_stall = (fill == QFILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `SPTS_ASSERT(a_fill_range, fill <= QFILL_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== src/sptseq_back.sv =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer back end
// Executes commands: element store, buffer bookkeeping, countdown and pins.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_pulse_train_sequencer_top_assert.svh"

module sptseq_back
  import sptseq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_stall,
  input  wire cmd_t q_cmd,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_LOAD  = 3'b100
  } state_t;

  state_t                 state, state_next;
  logic [NUM_BUFFERS-1:0] buffer_valid, buffer_valid_next;
  logic [BUF_W-1:0]       exec_buffer, exec_buffer_next;
  logic [ELEM_W-1:0]      elem_pointer, elem_pointer_next;
  logic [15:0]            toggles_done, toggles_done_next;
  logic [15:0]            steps_now, steps_now_next;
  logic [PERIOD_BITS-1:0] period_now, period_now_next;
  logic [PERIOD_BITS-1:0] countdown, countdown_next;
  logic                   run_flag, run_flag_next;
  logic                   pin_pulse, pin_pulse_next;
  logic                   pin_rot, pin_rot_next;
  logic                   pin_laser, pin_laser_next;
  logic                   underrun_flag, underrun_flag_next;

  elem_t             store [2**ADDR_W];
  elem_t             rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  logic              out_free;
  logic              emit;
  logic              done;
  logic [BUF_W-1:0]  buf_succ;
  result_t           result_next;

  assign out_free = !result_valid || !result_stall;
  assign q_stall  = !((state == S_IDLE) && out_free);
  assign buf_succ = (exec_buffer == BUF_W'(NUM_BUFFERS - 1)) ? '0
                                                             : exec_buffer + BUF_W'(1);

  always_comb begin
    state_next         = state;
    buffer_valid_next  = buffer_valid;
    exec_buffer_next   = exec_buffer;
    elem_pointer_next  = elem_pointer;
    toggles_done_next  = toggles_done;
    steps_now_next     = steps_now;
    period_now_next    = period_now;
    countdown_next     = countdown;
    run_flag_next      = run_flag;
    pin_pulse_next     = pin_pulse;
    pin_rot_next       = pin_rot;
    pin_laser_next     = pin_laser;
    underrun_flag_next = underrun_flag;
    emit               = 1'b0;
    done               = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = elem_addr(exec_buffer, elem_pointer);
    wr_en              = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          case (q_cmd.op)
            OP_WRITE: begin
              wr_en = 1'b1;
              emit  = 1'b1;
            end
            OP_MARK: begin
              buffer_valid_next[q_cmd.buf_idx] = 1'b1;
              emit = 1'b1;
            end
            OP_START: begin
              if (!run_flag && buffer_valid[exec_buffer]) begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
              end else begin
                emit = 1'b1;
              end
            end
            OP_TICK: begin
              if (!run_flag) begin
                emit = 1'b1;
              end else if (countdown > PERIOD_BITS'(1)) begin
                countdown_next = countdown - PERIOD_BITS'(1);
                emit = 1'b1;
              end else if ((steps_now != '0) &&
                           ({1'b0, toggles_done} + 17'd1 < {1'b0, steps_now})) begin
                pin_pulse_next    = ~pin_pulse;
                toggles_done_next = toggles_done + 16'd1;
                countdown_next    = period_now;
                emit = 1'b1;
              end else begin
                rd_en      = 1'b1;
                state_next = S_CHECK;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if (rd_data.stop || (elem_pointer == ELEM_W'(ELEMS_PER_BUFFER - 1) &&
                               !buffer_valid[buf_succ])) begin
            // The job ends here, either on a stop element or for lack of data.
            buffer_valid_next[exec_buffer] = 1'b0;
            pin_rot_next      = 1'b0;
            pin_laser_next    = 1'b1;
            exec_buffer_next  = '0;
            elem_pointer_next = '0;
            run_flag_next     = 1'b0;
            done              = rd_data.stop;
            if (!rd_data.stop) begin
              underrun_flag_next = 1'b1;
            end
            emit       = 1'b1;
            state_next = S_IDLE;
          end else if (elem_pointer == ELEM_W'(ELEMS_PER_BUFFER - 1)) begin
            buffer_valid_next[exec_buffer] = 1'b0;
            exec_buffer_next  = buf_succ;
            elem_pointer_next = '0;
            rd_en             = 1'b1;
            rd_addr           = elem_addr(buf_succ, '0);
            state_next        = S_LOAD;
          end else begin
            elem_pointer_next = elem_pointer + ELEM_W'(1);
            rd_en             = 1'b1;
            rd_addr           = elem_addr(exec_buffer, elem_pointer + ELEM_W'(1));
            state_next        = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          pin_rot_next      = rd_data.rot;
          pin_laser_next    = rd_data.laser;
          steps_now_next    = rd_data.steps;
          period_now_next   = rd_data.period;
          countdown_next    = rd_data.period;
          toggles_done_next = '0;
          pin_pulse_next    = 1'b1;
          run_flag_next     = 1'b1;
          emit              = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_next.pulse_level = pin_pulse_next;
    result_next.rot_pin     = pin_rot_next;
    result_next.laser_pin   = pin_laser_next;
    result_next.running     = run_flag_next;
    result_next.valid_mask  = 4'(buffer_valid_next);
    result_next.underrun    = underrun_flag_next;
    result_next.job_done    = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      buffer_valid  <= '0;
      exec_buffer   <= '0;
      elem_pointer  <= '0;
      toggles_done  <= '0;
      steps_now     <= '0;
      period_now    <= '0;
      countdown     <= '0;
      run_flag      <= 1'b0;
      pin_pulse     <= 1'b0;
      pin_rot       <= 1'b0;
      pin_laser     <= 1'b1;
      underrun_flag <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      buffer_valid  <= buffer_valid_next;
      exec_buffer   <= exec_buffer_next;
      elem_pointer  <= elem_pointer_next;
      toggles_done  <= toggles_done_next;
      steps_now     <= steps_now_next;
      period_now    <= period_now_next;
      countdown     <= countdown_next;
      run_flag      <= run_flag_next;
      pin_pulse     <= pin_pulse_next;
      pin_rot       <= pin_rot_next;
      pin_laser     <= pin_laser_next;
      underrun_flag <= underrun_flag_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[q_cmd.addr] <= q_cmd.elem;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  `SPTS_ASSERT_SAME(a_run_buf_valid, run_flag, buffer_valid[exec_buffer])
  `SPTS_ASSERT_SAME(a_underrun_stops, $rose(underrun_flag), !run_flag)
  `SPTS_ASSERT_NEXT(a_read_then_use, (state == S_IDLE) && rd_en, state == S_CHECK || state == S_LOAD)

endmodule

`default_nettype wire

// ===== bench/step_pulse_train_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Step pulse train sequencer testbench
// Plans command beats against a shadow copy of the sequencer so that only
// fully written buffers are ever marked valid. Jobs span one to four buffers,
// ending on stop elements or underrun, with random writes, marks and starts
// mixed into the tick stream. Every accepted command beat is run through an
// independent model of the sequencer, and each result beat is compared field
// by field with the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module step_pulse_train_sequencer_top_tb;
  import sptseq_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int IDLE_PCT       = 13;
  localparam int WORK_TARGET    = 600;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LINES          = NUM_BUFFERS * ELEMS_PER_BUFFER;

  typedef struct packed {
    elem_t [LINES-1:0]      store;
    logic [NUM_BUFFERS-1:0] valid;
    logic [BUF_W-1:0]       exec_buf;
    logic [ELEM_W-1:0]      ptr;
    logic [15:0]            toggles;
    logic [15:0]            steps;
    logic [PERIOD_BITS-1:0] period;
    logic [PERIOD_BITS-1:0] countdown;
    logic                   run;
    logic                   pulse;
    logic                   rot;
    logic                   laser;
    logic                   underrun;
  } seq_state_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  seq_state_t live_state;
  seq_state_t plan_state;
  logic [LINES-1:0] line_safe;
  item_t   command_backlog[$];
  result_t predicted_status[$];

  int planned_work = 0;
  int cycle_count = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int commands_sent = 0;
  int status_checked = 0;
  int stops_seen = 0;
  int handovers = 0;
  logic underrun_seen = 1'b0;

  wire calm = (cycle_count >= 250) && (cycle_count < 500);
  wire command_beat = item_valid && !item_stall;
  wire status_beat = result_valid && !result_stall;

  step_pulse_train_sequencer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic seq_state_t reset_sequencer_state();
    seq_state_t s;
    s = '0;
    s.laser = 1'b1;
    return s;
  endfunction

  function automatic void load_line(inout seq_state_t s, input elem_t e);
    s.rot = e.rot;
    s.laser = e.laser;
    s.steps = e.steps;
    s.period = e.period;
    s.countdown = e.period;
    s.toggles = '0;
    s.pulse = 1'b1;
  endfunction

  function automatic void park_sequencer(inout seq_state_t s);
    s.valid[s.exec_buf] = 1'b0;
    s.rot = 1'b0;
    s.laser = 1'b1;
    s.exec_buf = '0;
    s.ptr = '0;
    s.run = 1'b0;
  endfunction

  function automatic logic line_expired(inout seq_state_t s);
    logic [BUF_W-1:0] nxt;
    if (s.steps != 16'd0 && ({1'b0, s.toggles} + 17'd1) < {1'b0, s.steps}) begin
      s.pulse = ~s.pulse;
      s.toggles = s.toggles + 16'd1;
      return 1'b0;
    end
    if (s.store[{s.exec_buf, s.ptr}].stop) begin
      park_sequencer(s);
      return 1'b1;
    end
    if (s.ptr == ELEM_W'(ELEMS_PER_BUFFER - 1)) begin
      nxt = s.exec_buf + BUF_W'(1);
      if (!s.valid[nxt]) begin
        park_sequencer(s);
        s.underrun = 1'b1;
        return 1'b0;
      end
      s.valid[s.exec_buf] = 1'b0;
      s.exec_buf = nxt;
      s.ptr = '0;
    end else begin
      s.ptr = s.ptr + ELEM_W'(1);
    end
    load_line(s, s.store[{s.exec_buf, s.ptr}]);
    return 1'b0;
  endfunction

  function automatic result_t advance_sequencer(inout seq_state_t s, input item_t it);
    result_t r;
    elem_t e;
    logic done;
    done = 1'b0;
    case (it.func)
      FUNC_WRITE: begin
        e.steps = it.step_count;
        e.period = it.period_ticks;
        e.rot = it.rot_flag;
        e.laser = it.laser_flag;
        e.stop = it.stop_flag;
        s.store[{it.buf_sel, it.elem_index}] = e;
      end
      FUNC_MARK: begin
        s.valid[it.buf_sel] = 1'b1;
      end
      FUNC_START: begin
        if (!s.run && s.valid[s.exec_buf]) begin
          load_line(s, s.store[{s.exec_buf, s.ptr}]);
          s.run = 1'b1;
        end
      end
      default: begin
        if (s.run) begin
          if (s.countdown <= PERIOD_BITS'(1)) begin
            done = line_expired(s);
            if (s.run) s.countdown = s.period;
          end else begin
            s.countdown = s.countdown - PERIOD_BITS'(1);
          end
        end
      end
    endcase
    r.pulse_level = s.pulse;
    r.rot_pin = s.rot;
    r.laser_pin = s.laser;
    r.running = s.run;
    r.valid_mask = s.valid;
    r.underrun = s.underrun;
    r.job_done = done;
    return r;
  endfunction

  function automatic item_t random_item(input logic [1:0] f);
    item_t it;
    it.func = f;
    it.buf_sel = 2'($urandom);
    it.elem_index = 4'($urandom);
    it.step_count = 16'($urandom);
    it.period_ticks = 24'($urandom);
    it.rot_flag = 1'($urandom);
    it.laser_flag = 1'($urandom);
    it.stop_flag = 1'($urandom);
    return it;
  endfunction

  task automatic issue(input item_t it);
    if (it.func == FUNC_WRITE || it.func == FUNC_MARK ||
        (it.func == FUNC_TICK && plan_state.run) ||
        (it.func == FUNC_START && !plan_state.run && plan_state.valid[plan_state.exec_buf]))
      planned_work++;
    void'(advance_sequencer(plan_state, it));
    command_backlog.push_back(it);
  endtask

  task automatic put_line(input logic [1:0] b, input logic [3:0] i, input logic [15:0] n,
                          input logic [23:0] p, input logic r, input logic l,
                          input logic st);
    item_t it;
    it = random_item(FUNC_WRITE);
    it.buf_sel = b;
    it.elem_index = i;
    it.step_count = n;
    it.period_ticks = p;
    it.rot_flag = r;
    it.laser_flag = l;
    it.stop_flag = st;
    issue(it);
    line_safe[{b, i}] = (n <= 16'd6) && (p <= 24'd4);
  endtask

  task automatic put_small_line(input logic [1:0] b, input logic [3:0] i, input int stop_pct);
    put_line(b, i, 16'($urandom_range(0, 4)), 24'($urandom_range(0, 3)), 1'($urandom),
             1'($urandom), $urandom_range(0, 99) < stop_pct);
  endtask

  task automatic arm_buffer(input logic [1:0] b);
    item_t it;
    for (int i = 0; i < ELEMS_PER_BUFFER; i++)
      if (!line_safe[{b, 4'(i)}]) put_small_line(b, 4'(i), 8);
    it = random_item(FUNC_MARK);
    it.buf_sel = b;
    issue(it);
  endtask

  task automatic stir();
    logic [1:0] b;
    b = 2'($urandom);
    case ($urandom_range(0, 3))
      0: put_small_line(b, 4'($urandom), 10);
      1: begin
        if (!plan_state.valid[b])
          put_line(b, 4'($urandom), 16'($urandom), 24'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
        else
          put_small_line(b, 4'($urandom), 10);
      end
      2: issue(random_item(FUNC_START));
      default: arm_buffer(b);
    endcase
  endtask

  task automatic run_ticks(input int limit, input int noise_pct);
    int n;
    n = 0;
    while (plan_state.run && n < limit) begin
      if ($urandom_range(0, 99) < noise_pct) stir();
      else issue(random_item(FUNC_TICK));
      n++;
    end
  endtask

  task automatic plan_job();
    int span;
    logic [1:0] b;
    span = $urandom_range(1, NUM_BUFFERS);
    for (int k = 0; k < span; k++) begin
      b = plan_state.exec_buf + 2'(k);
      repeat ($urandom_range(0, 4)) put_small_line(b, 4'($urandom), 12);
      if (k == 0 || $urandom_range(0, 2) != 0) arm_buffer(b);
    end
    issue(random_item(FUNC_START));
    run_ticks(1500, 6);
    repeat ($urandom_range(0, 3)) issue(random_item(FUNC_TICK));
    if ($urandom_range(0, 3) == 0) issue(random_item(FUNC_START));
  endtask

  task automatic compare_field(input string name, input logic [3:0] want_v,
                               input logic [3:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin : drive
    result_t r;
    logic [BUF_W-1:0] exec_before;
    logic busy_before;
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
    end else begin
      if (command_beat) begin
        exec_before = live_state.exec_buf;
        busy_before = live_state.run;
        r = advance_sequencer(live_state, item);
        predicted_status.push_back(r);
        if (r.job_done) stops_seen++;
        if (r.underrun) underrun_seen = 1'b1;
        if (busy_before && live_state.run && exec_before != live_state.exec_buf) handovers++;
        commands_sent++;
      end
      if (!item_valid || !item_stall) begin
        if (command_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item_valid <= 1'b1;
          item <= command_backlog.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (status_beat) begin
        if (predicted_status.size() == 0) begin
          $error("result beat arrived with nothing expected");
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          compare_field("pulse_level", 4'(want.pulse_level), 4'(result.pulse_level));
          compare_field("rot_pin", 4'(want.rot_pin), 4'(result.rot_pin));
          compare_field("laser_pin", 4'(want.laser_pin), 4'(result.laser_pin));
          compare_field("running", 4'(want.running), 4'(result.running));
          compare_field("valid_mask", want.valid_mask, result.valid_mask);
          compare_field("underrun", 4'(want.underrun), 4'(result.underrun));
          compare_field("job_done", 4'(want.job_done), 4'(result.job_done));
        end
        status_checked++;
      end
      result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || command_beat || status_beat) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    live_state = reset_sequencer_state();
    plan_state = live_state;
    line_safe = '0;

    issue(random_item(FUNC_TICK));
    issue(random_item(FUNC_START));
    put_line(2'd3, 4'd15, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    put_line(2'd2, 4'd0, 16'd0, 24'd0, 1'b0, 1'b0, 1'b0);
    put_line(2'd0, 4'd0, 16'd0, 24'd0, 1'b0, 1'b0, 1'b0);
    put_line(2'd0, 4'd1, 16'd1, 24'd1, 1'b1, 1'b0, 1'b0);
    put_line(2'd0, 4'd2, 16'd3, 24'd2, 1'b1, 1'b1, 1'b0);
    for (int i = 3; i < ELEMS_PER_BUFFER; i++) put_small_line(2'd0, 4'(i), 0);
    arm_buffer(2'd0);
    issue(random_item(FUNC_START));
    issue(random_item(FUNC_START));
    run_ticks(2000, 0);

    while (planned_work < WORK_TARGET) plan_job();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (command_backlog.size() != 0 || item_valid || predicted_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d command beats and %0d result beats checked.",
             commands_sent, status_checked);
    $display("Jobs ended on a stop element: %0d, buffer hand-overs: %0d, underrun seen: %0d.",
             stops_seen, handovers, underrun_seen);
    if (mismatches == 0 && predicted_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/sptseq_pkg.sv
src/sptseq_front.sv
src/sptseq_queue.sv
src/sptseq_back.sv
src/step_pulse_train_sequencer_top.sv
bench/step_pulse_train_sequencer_top_tb.sv
